/* rtl/lzw_encoder_assert.svh */
// Assertion macros for the LZW encoder.
// Expects clk and rst_n in the scope of every use.
`ifndef LZW_ENCODER_ASSERT_SVH
`define LZW_ENCODER_ASSERT_SVH

// same-cycle implication
`define LZWE_ASSERT_NOW(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define LZWE_ASSERT_NEXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

/* rtl/lzwe_pkg.sv */
// Package for the LZW encoder: sizes and payload structs.
// No dependencies.
`default_nettype none
package lzwe_pkg;

  localparam int MAX_CODE_BITS     = 12;
  localparam int INITIAL_CODE_BITS = 9;
  localparam int ROOT_CODES        = 256;

  localparam int BYTE_W   = 8;
  localparam int WIDTH_W  = 4;
  localparam int NEXT_W   = MAX_CODE_BITS + 1;
  localparam int ROOT_W   = $clog2(ROOT_CODES);
  localparam int DICT_DEPTH = 1 << MAX_CODE_BITS;
  localparam int NODE_W   = MAX_CODE_BITS + BYTE_W;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [MAX_CODE_BITS-1:0] code;
    logic [WIDTH_W-1:0]       code_width;
    logic                     final_code;
  } out_item_t;

endpackage
`default_nettype wire

/* rtl/lzwe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lzwe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/lzwe_out_reg.sv */
// Output register for result transactions of the LZW encoder.
// Depends on lzwe_pkg.
`default_nettype none
module lzwe_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire lzwe_pkg::out_item_t push_data,
  output logic                     can_load,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lzwe_pkg::out_item_t      out_data
);

  logic                valid_r;
  lzwe_pkg::out_item_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/lzw_encoder.sv */
// LZW encoder top level: sequencer, child-link RAM, node RAM and output register.
// Depends on lzwe_pkg, lzwe_ram, lzwe_out_reg and lzw_encoder_assert.svh.
//
//   channel  | ports                        | moves
//   ---------+------------------------------+---------------------------------
//   input    | in_valid, in_ready, in_data  | data_byte, end_of_input
//   result   | out_valid, out_ready, out_data | code, code_width, final_code
//
// First byte of a stream: taken in the idle state. Other bytes: a child-link read, then the
// child-list nodes of the prefix visited one by one through the node RAM read port;
// a miss adds emit, insert and link clear steps, only the emit once the dictionary is full,
// and end of input adds a final emit step.
// One transaction at a time: in_ready is high only between items.
// Emit steps hold while the output register is full. Reset is synchronous
// and needs no clearing pass.
`default_nettype none
`include "lzw_encoder_assert.svh"
module lzw_encoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lzwe_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lzwe_pkg::out_item_t     out_data
);

  localparam int CW  = lzwe_pkg::MAX_CODE_BITS;
  localparam int NW  = lzwe_pkg::NEXT_W;
  localparam int WW  = lzwe_pkg::WIDTH_W;
  localparam int BW  = lzwe_pkg::BYTE_W;
  localparam int RW  = lzwe_pkg::ROOT_W;
  localparam int RC  = lzwe_pkg::ROOT_CODES;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHILD = 3'd1;
  localparam logic [2:0] S_NODE  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_INS   = 3'd4;
  localparam logic [2:0] S_CLR   = 3'd5;
  localparam logic [2:0] S_FINAL = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] prefix_r, prefix_nxt;
  logic          prefix_valid_r, prefix_valid_nxt;
  logic [NW-1:0] next_free_r, next_free_nxt;
  logic [WW-1:0] width_r, width_nxt;
  logic [RC-1:0] root_seen_r, root_seen_nxt;
  logic [BW-1:0] byte_r, byte_nxt;
  logic          eoi_r, eoi_nxt;
  logic [CW-1:0] head_r, head_nxt;
  logic [CW-1:0] walk_r, walk_nxt;

  logic          child_we;
  logic [CW-1:0] child_waddr, child_wdata, child_rdata;
  logic          node_we;
  logic [lzwe_pkg::NODE_W-1:0] node_wdata, node_rdata;
  logic [CW-1:0] head;
  logic [CW-1:0] node_sib;
  logic [BW-1:0] node_byte;
  logic          prefix_is_root;

  logic                out_push;
  logic                out_can_load;
  lzwe_pkg::out_item_t push_data;

  assign in_ready       = (state_r == S_IDLE);
  assign prefix_is_root = (prefix_r < CW'(RC));
  assign head           = (prefix_is_root && !root_seen_r[prefix_r[RW-1:0]]) ? '0 : child_rdata;
  assign node_sib       = node_rdata[lzwe_pkg::NODE_W-1:BW];
  assign node_byte      = node_rdata[BW-1:0];
  assign node_wdata     = {head_r, byte_r};

  always_comb begin
    state_nxt        = state_r;
    prefix_nxt       = prefix_r;
    prefix_valid_nxt = prefix_valid_r;
    next_free_nxt    = next_free_r;
    width_nxt        = width_r;
    root_seen_nxt    = root_seen_r;
    byte_nxt         = byte_r;
    eoi_nxt          = eoi_r;
    head_nxt         = head_r;
    walk_nxt         = walk_r;
    child_we         = 1'b0;
    child_waddr      = prefix_r;
    child_wdata      = next_free_r[CW-1:0];
    node_we          = 1'b0;
    out_push         = 1'b0;
    push_data.code       = prefix_r;
    push_data.code_width = width_r;
    push_data.final_code = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_data.data_byte;
          eoi_nxt  = in_data.end_of_input;
          if (!prefix_valid_r) begin
            prefix_nxt       = CW'(in_data.data_byte);
            prefix_valid_nxt = 1'b1;
            state_nxt        = in_data.end_of_input ? S_FINAL : S_IDLE;
          end else begin
            state_nxt = S_CHILD;
          end
        end
      end
      S_CHILD: begin
        head_nxt = head;
        walk_nxt = head;
        state_nxt = (head == '0) ? S_EMIT : S_NODE;
      end
      S_NODE: begin
        if (node_byte == byte_r) begin
          prefix_nxt = walk_r;
          state_nxt  = eoi_r ? S_FINAL : S_IDLE;
        end else if (node_sib == '0) begin
          state_nxt = S_EMIT;
        end else begin
          walk_nxt = node_sib;
        end
      end
      S_EMIT: begin
        if (out_can_load) begin
          out_push = 1'b1;
          if (!next_free_r[NW-1]) begin
            state_nxt = S_INS;
          end else begin
            prefix_nxt = CW'(byte_r);
            state_nxt  = eoi_r ? S_FINAL : S_IDLE;
          end
        end
      end
      S_INS: begin
        child_we = 1'b1;
        node_we  = 1'b1;
        if (prefix_is_root) begin
          root_seen_nxt[prefix_r[RW-1:0]] = 1'b1;
        end
        state_nxt = S_CLR;
      end
      S_CLR: begin
        child_we    = 1'b1;
        child_waddr = next_free_r[CW-1:0];
        child_wdata = '0;
        next_free_nxt = next_free_r + NW'(1);
        if (((next_free_r >> width_r) != '0) && (width_r < WW'(CW))) begin
          width_nxt = width_r + WW'(1);
        end
        prefix_nxt = CW'(byte_r);
        state_nxt  = eoi_r ? S_FINAL : S_IDLE;
      end
      S_FINAL: begin
        push_data.final_code = 1'b1;
        if (out_can_load) begin
          out_push         = 1'b1;
          prefix_nxt       = '0;
          prefix_valid_nxt = 1'b0;
          next_free_nxt    = NW'(RC);
          width_nxt        = WW'(lzwe_pkg::INITIAL_CODE_BITS);
          root_seen_nxt    = '0;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      prefix_r       <= '0;
      prefix_valid_r <= 1'b0;
      next_free_r    <= NW'(RC);
      width_r        <= WW'(lzwe_pkg::INITIAL_CODE_BITS);
      root_seen_r    <= '0;
    end else begin
      state_r        <= state_nxt;
      prefix_r       <= prefix_nxt;
      prefix_valid_r <= prefix_valid_nxt;
      next_free_r    <= next_free_nxt;
      width_r        <= width_nxt;
      root_seen_r    <= root_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    eoi_r  <= eoi_nxt;
    head_r <= head_nxt;
    walk_r <= walk_nxt;
  end

  lzwe_ram #(
    .WIDTH (CW),
    .DEPTH (lzwe_pkg::DICT_DEPTH)
  ) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .raddr (prefix_r),
    .rdata (child_rdata)
  );

  lzwe_ram #(
    .WIDTH (lzwe_pkg::NODE_W),
    .DEPTH (lzwe_pkg::DICT_DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (next_free_r[CW-1:0]),
    .wdata (node_wdata),
    .raddr (walk_nxt),
    .rdata (node_rdata)
  );

  lzwe_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (out_push),
    .push_data (push_data),
    .can_load  (out_can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `LZWE_ASSERT_NOW(a_width_range, 1'b1, (width_r >= WW'(lzwe_pkg::INITIAL_CODE_BITS)) && (width_r <= WW'(CW)), "code width out of range")
  `LZWE_ASSERT_NOW(a_next_free_range, 1'b1, (next_free_r >= NW'(RC)) && (next_free_r <= NW'(lzwe_pkg::DICT_DEPTH)), "next free code out of range")
  `LZWE_ASSERT_NOW(a_push_gated, out_push, out_can_load, "push into a full output register")
  `LZWE_ASSERT_NEXT(a_final_clears, (state_r == S_FINAL) && out_can_load, !prefix_valid_r && (next_free_r == NW'(RC)) && (root_seen_r == '0), "stream end did not clear state")

endmodule
`default_nettype wire

/* tb/lzw_encoder_tb.sv */
// Self-checking testbench for lzw_encoder: streams of bytes in, codes checked against a predictor.
// Depends on lzwe_pkg and the lzw_encoder RTL.
module lzw_encoder_tb;
  import lzwe_pkg::*;

  typedef enum int {ANY_BYTE, FEW_SYMBOLS, ONE_RUN} stream_kind_e;
  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_TOGGLE} ready_mode_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  pending_bytes[$];
  out_item_t expected_codes[$];
  int        code_mismatches = 0;
  int        codes_seen = 0;
  bit        in_taken = 1'b0;

  logic [MAX_CODE_BITS-1:0] pair_code[logic [NODE_W-1:0]];
  logic [MAX_CODE_BITS-1:0] cur_prefix = '0;
  bit                       have_prefix = 1'b0;
  logic [NEXT_W-1:0]        next_code = NEXT_W'(ROOT_CODES);
  logic [WIDTH_W-1:0]       cur_width = WIDTH_W'(INITIAL_CODE_BITS);

  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;
  int          phase_cnt = 0;
  ready_mode_e ready_mode = READY_ALWAYS;

  lzw_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic push_code(input logic [MAX_CODE_BITS-1:0] code, input logic is_final);
    out_item_t item;
    item.code       = code;
    item.code_width = cur_width;
    item.final_code = is_final;
    expected_codes.push_back(item);
  endtask

  task automatic predict_codes(input in_item_t item);
    logic [NODE_W-1:0] key;
    key = {cur_prefix, item.data_byte};
    if (!have_prefix) begin
      cur_prefix  = MAX_CODE_BITS'(item.data_byte);
      have_prefix = 1'b1;
    end else if (pair_code.exists(key)) begin
      cur_prefix = pair_code[key];
    end else begin
      push_code(cur_prefix, 1'b0);
      if (next_code < NEXT_W'(DICT_DEPTH)) begin
        pair_code[key] = next_code[MAX_CODE_BITS-1:0];
        if (next_code >= (NEXT_W'(1) << cur_width) && cur_width < WIDTH_W'(MAX_CODE_BITS))
          cur_width = cur_width + 1'b1;
        next_code = next_code + 1'b1;
      end
      cur_prefix = MAX_CODE_BITS'(item.data_byte);
    end
    if (item.end_of_input) begin
      push_code(cur_prefix, 1'b1);
      pair_code.delete();
      cur_prefix  = '0;
      have_prefix = 1'b0;
      next_code   = NEXT_W'(ROOT_CODES);
      cur_width   = WIDTH_W'(INITIAL_CODE_BITS);
    end
  endtask

  task automatic report_mismatch(input string what, input out_item_t want, input out_item_t got);
    code_mismatches++;
    if (code_mismatches <= 10)
      $display("%s: expected code %0d width %0d final %0b, got code %0d width %0d final %0b",
               what, want.code, want.code_width, want.final_code,
               got.code, got.code_width, got.final_code);
  endtask

  task automatic add_byte(input logic [BYTE_W-1:0] value, input logic last);
    in_item_t item;
    item.data_byte    = value;
    item.end_of_input = last;
    pending_bytes.push_back(item);
  endtask

  task automatic add_stream(input int len, input stream_kind_e kind);
    logic [BYTE_W-1:0] symbols[8];
    int                n_symbols;
    logic [BYTE_W-1:0] value;
    n_symbols = $urandom_range(2, 8);
    foreach (symbols[i]) symbols[i] = BYTE_W'($urandom_range(0, 255));
    value = BYTE_W'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      case (kind)
        ANY_BYTE:    value = BYTE_W'($urandom_range(0, 255));
        FEW_SYMBOLS: value = symbols[$urandom_range(0, n_symbols - 1)];
        default:     value = value;
      endcase
      add_byte(value, i == len - 1);
    end
  endtask

  // check results, then predict for the transaction accepted at this edge
  always @(posedge clk) begin
    out_item_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        codes_seen++;
        if (expected_codes.size() == 0) begin
          report_mismatch("unexpected code", '0, out_data);
        end else begin
          want = expected_codes.pop_front();
          if (out_data.code !== want.code || out_data.code_width !== want.code_width ||
              out_data.final_code !== want.final_code)
            report_mismatch("code mismatch", want, out_data);
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        predict_codes(in_data);
      end
    end
  end

  always @(negedge clk) begin
    logic nxt_valid;
    nxt_valid = in_valid;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && in_taken) nxt_valid = 1'b0;
      if (!nxt_valid && pending_bytes.size() != 0) begin
        if (gap_left != 0 && hold_left == 0) begin
          gap_left--;
        end else begin
          in_data <= pending_bytes.pop_front();
          nxt_valid = 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
    in_valid <= nxt_valid;
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && codes_seen >= 200) begin
      long_hold_done = 1'b1;
      hold_left      = 500;
      out_ready <= 1'b0;
    end else begin
      phase_cnt++;
      if (phase_cnt % 50 == 0) ready_mode = ready_mode_e'($urandom_range(0, 3));
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        READY_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
        default:      out_ready <= phase_cnt[2];
      endcase
    end
  end

  initial begin
    int  random_items;
    int  pick;
    int  len;
    bit  fill_done;
    random_items = 0;
    fill_done    = 1'b0;

    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b1);
    repeat (5) add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    for (int i = 0; i < 7; i++) add_byte((i % 2 == 0) ? 8'h41 : 8'h42, i == 6);
    add_byte(8'h55, 1'b0);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h80, 1'b1);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h7F, 1'b1);

    while (random_items < 1150) begin
      if (!fill_done && random_items >= 300) begin
        // grow the code width in one long stream
        add_stream(600, ANY_BYTE);
        random_items += 600;
        fill_done = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        len = 1;
        add_stream(len, ANY_BYTE);
      end else if (pick < 6) begin
        len = $urandom_range(2, 40);
        add_stream(len, ANY_BYTE);
      end else if (pick < 15) begin
        len = $urandom_range(5, 80);
        add_stream(len, FEW_SYMBOLS);
      end else if (pick < 18) begin
        len = $urandom_range(2, 60);
        add_stream(len, ONE_RUN);
      end else if (pick == 18) begin
        len = $urandom_range(150, 250);
        add_stream(len, FEW_SYMBOLS);
      end else begin
        len = $urandom_range(300, 400);
        add_stream(len, ANY_BYTE);
      end
      random_items += len;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid || expected_codes.size() != 0)
      @(posedge clk);
    repeat (32) @(posedge clk);

    if (code_mismatches == 0 && expected_codes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
